FILE: design/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W              = 13;
    localparam int CH_W               = 8;
    localparam int HUE_FRAC_BITS_DEF  = 4;

    localparam int SECTOR_DEG         = 60;
    localparam int TURN_DEG           = 360;
    localparam int CH_MAX             = 255;

    // After the hue scaling is shifted away, each level divides by 255 * 60.
    localparam int DIV_BASE           = CH_MAX * SECTOR_DEG;
    localparam int XW                 = $clog2((CH_MAX + 1) * DIV_BASE);
    localparam int RECIP_SH           = XW + $clog2(DIV_BASE);
    localparam longint unsigned RECIP_M =
        ((64'd1 << RECIP_SH) + DIV_BASE - 1) / DIV_BASE;
    localparam int RECIP_W            = $clog2(RECIP_M + 1);

    localparam int S_TDATA_W          = 32;
    localparam int M_TDATA_W          = 24;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } sector_t;

    // Per-pixel data that rides alongside the arithmetic lanes.
    typedef struct packed {
        sector_t          sector;
        logic             grey;
        logic [CH_W-1:0]  sat;
        logic [CH_W-1:0]  val;
    } pix_side_t;

    // Load enables for the three register stages inside a lane.
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } lane_en_t;

endpackage

`default_nettype wire

FILE: design/hsv2rgb_sector.sv
// First stage: hue wrap, sector split and remainder within the sector.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_sector
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [HUE_W-1:0]     hue,
    input  wire logic [CH_W-1:0]      sat,
    input  wire logic [CH_W-1:0]      val,
    output      pix_side_t            side,
    output      logic [$clog2((SECTOR_DEG << HUE_FRACTION_BITS) + 1)-1:0] rem
);

    localparam int SECTOR_UNITS = SECTOR_DEG << HUE_FRACTION_BITS;
    localparam int TURN_UNITS   = TURN_DEG << HUE_FRACTION_BITS;
    localparam int RW           = $clog2(SECTOR_UNITS + 1);
    localparam int TW           = $clog2(TURN_UNITS + 1);
    localparam int CW           = (TW > HUE_W) ? TW : HUE_W;

    logic [CW-1:0] hue_ext;
    logic [CW-1:0] hue_wrap;
    logic [CW-1:0] base;
    sector_t       sector_next;
    pix_side_t     side_reg;
    logic [RW-1:0] rem_reg;
    logic [CW-1:0] rem_full;

    always_comb begin
        hue_ext  = CW'(hue);
        hue_wrap = (hue_ext >= CW'(TURN_UNITS)) ? '0 : hue_ext;
        if (hue_wrap >= CW'(5 * SECTOR_UNITS)) begin
            sector_next = SEC_5;
            base        = CW'(5 * SECTOR_UNITS);
        end else if (hue_wrap >= CW'(4 * SECTOR_UNITS)) begin
            sector_next = SEC_4;
            base        = CW'(4 * SECTOR_UNITS);
        end else if (hue_wrap >= CW'(3 * SECTOR_UNITS)) begin
            sector_next = SEC_3;
            base        = CW'(3 * SECTOR_UNITS);
        end else if (hue_wrap >= CW'(2 * SECTOR_UNITS)) begin
            sector_next = SEC_2;
            base        = CW'(2 * SECTOR_UNITS);
        end else if (hue_wrap >= CW'(SECTOR_UNITS)) begin
            sector_next = SEC_1;
            base        = CW'(SECTOR_UNITS);
        end else begin
            sector_next = SEC_0;
            base        = '0;
        end
        rem_full = hue_wrap - base;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg.sector <= sector_next;
            side_reg.grey   <= (sat == '0);
            side_reg.sat    <= sat;
            side_reg.val    <= val;
            rem_reg         <= rem_full[RW-1:0];
        end
    end

    assign side = side_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

FILE: design/hsv2rgb_lane.sv
// One arithmetic lane: V * (1 - S * span / sector), rounded, over three stages.
`timescale 1ns / 1ps
`default_nettype none

module hsv2rgb_lane
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire lane_en_t             en,
    input  wire logic [CH_W-1:0]      sat,
    input  wire logic [$clog2((SECTOR_DEG << HUE_FRACTION_BITS) + 1)-1:0] span,
    input  wire logic [CH_W-1:0]      val,
    output      logic [CH_W-1:0]      level
);

    localparam int SECTOR_UNITS = SECTOR_DEG << HUE_FRACTION_BITS;
    localparam int RW           = $clog2(SECTOR_UNITS + 1);
    localparam int FULL         = CH_MAX * SECTOR_UNITS;
    localparam int HALF         = FULL / 2;
    localparam int WW           = $clog2(FULL + 1);
    localparam int NW           = WW + CH_W;
    localparam int SW           = NW + 1;
    localparam int PW           = XW + RECIP_W;

    logic [RW+CH_W-1:0] sr;
    logic [WW-1:0]      w_next;
    logic [WW-1:0]      w_reg;
    logic [NW-1:0]      n_next;
    logic [NW-1:0]      n_reg;
    logic [SW-1:0]      sum;
    logic [SW-1:0]      sum_sh;
    logic [PW-1:0]      prod_next;
    logic [PW-1:0]      prod_reg;

    always_comb begin
        sr     = (RW + CH_W)'(sat) * (RW + CH_W)'(span);
        w_next = WW'(FULL) - WW'(sr);
    end

    assign n_next = NW'(val) * NW'(w_reg);

    // Rounding offset, then the power-of-two part of the divisor is shifted out;
    // the remaining divide by 255 * 60 is an exact reciprocal multiply.
    always_comb begin
        sum       = SW'(n_reg) + SW'(HALF);
        sum_sh    = sum >> HUE_FRACTION_BITS;
        prod_next = PW'(sum_sh[XW-1:0]) * PW'(RECIP_M);
    end

    always_ff @(posedge aclk) begin
        if (en.ld2) begin
            w_reg <= w_next;
        end
        if (en.ld3) begin
            n_reg <= n_next;
        end
        if (en.ld4) begin
            prod_reg <= prod_next;
        end
    end

    assign level = prod_reg[RECIP_SH +: CH_W];

endmodule

`default_nettype wire

FILE: design/hsv_to_rgb_converter_core.sv
// Top level of the pipelined HSV to RGB color converter.
// Usage: one HSV pixel enters per beat on the s_ stream and one RGB pixel
// leaves per beat on the m_ stream, in the same order.
// The input beat carries hue in 1/2^HUE_FRACTION_BITS degree units; a hue of a
// full turn or more is taken as zero. Saturation and brightness are 8-bit
// fractions of 255, and zero saturation gives grey at the brightness level.
// An accepted input beat reaches m_tvalid through five register stages: sector
// split, S*span product, V multiply, reciprocal divide multiply, and the output
// register where channels are picked by sector.
// Throughput is one pixel per clock while m_tready is high: every stage then moves.
// Each stage has its own valid bit and loads when it is empty or when the stage
// after it moves, so bubbles are squeezed out and s_tready stays high while any
// stage is free, even with a finished pixel waiting at the output.
// When the receiver holds m_tready low the output beat holds and the pipe
// fills up; s_tready falls only once all five stages hold pixels.
// Reset (aresetn low at a clock edge) empties the pipe; data registers are not
// cleared and nothing leaves until new beats arrive.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgb_converter_core
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRACTION_BITS = HUE_FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output      logic                  s_tready,
    // Fields from bit 0: hue[12:0], saturation[20:13], brightness[28:21], zero pad.
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output      logic                  m_tvalid,
    input  wire logic                  m_tready,
    // Fields from bit 0: red[7:0], green[15:8], blue[23:16].
    output      logic [M_TDATA_W-1:0]  m_tdata
);

    localparam int SECTOR_UNITS = SECTOR_DEG << HUE_FRACTION_BITS;
    localparam int RW           = $clog2(SECTOR_UNITS + 1);
    localparam int NSTAGE       = 5;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE-1:0] ld;

    pix_side_t     side1;
    pix_side_t     side2_reg;
    pix_side_t     side3_reg;
    pix_side_t     side4_reg;
    logic [RW-1:0] rem1;
    logic [RW-1:0] span_q;
    logic [RW-1:0] span_t;
    logic [RW-1:0] span_p;
    lane_en_t      lane_en;
    logic [CH_W-1:0] lvl_q;
    logic [CH_W-1:0] lvl_t;
    logic [CH_W-1:0] lvl_p;

    logic [CH_W-1:0] red_reg;
    logic [CH_W-1:0] green_reg;
    logic [CH_W-1:0] blue_reg;
    logic [CH_W-1:0] red_next;
    logic [CH_W-1:0] green_next;
    logic [CH_W-1:0] blue_next;

    // A stage loads when it is empty or when the stage after it loads too.
    always_comb begin
        ld[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            ld[k] = !valid_reg[k] || ld[k+1];
        end
        valid_next[0] = ld[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTAGE; k++) begin
            valid_next[k] = ld[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = ld[0];

    hsv2rgb_sector #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_sector (
        .aclk (aclk),
        .en   (ld[0]),
        .hue  (s_tdata[HUE_W-1:0]),
        .sat  (s_tdata[HUE_W +: CH_W]),
        .val  (s_tdata[HUE_W + CH_W +: CH_W]),
        .side (side1),
        .rem  (rem1)
    );

    // q uses the remainder, t its complement, and p a whole sector (V * (1 - S)).
    assign span_q = rem1;
    assign span_t = RW'(SECTOR_UNITS) - rem1;
    assign span_p = RW'(SECTOR_UNITS);

    assign lane_en.ld2 = ld[1];
    assign lane_en.ld3 = ld[2];
    assign lane_en.ld4 = ld[3];

    hsv2rgb_lane #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_lane_q (
        .aclk  (aclk),
        .en    (lane_en),
        .sat   (side1.sat),
        .span  (span_q),
        .val   (side2_reg.val),
        .level (lvl_q)
    );

    hsv2rgb_lane #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_lane_t (
        .aclk  (aclk),
        .en    (lane_en),
        .sat   (side1.sat),
        .span  (span_t),
        .val   (side2_reg.val),
        .level (lvl_t)
    );

    hsv2rgb_lane #(
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_lane_p (
        .aclk  (aclk),
        .en    (lane_en),
        .sat   (side1.sat),
        .span  (span_p),
        .val   (side2_reg.val),
        .level (lvl_p)
    );

    // Sector, grey flag and brightness travel beside the lanes.
    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            side2_reg <= side1;
        end
        if (ld[2]) begin
            side3_reg <= side2_reg;
        end
        if (ld[3]) begin
            side4_reg <= side3_reg;
        end
    end

    // Channel selection by sector; grey pixels take all three channels from the brightness.
    always_comb begin
        case (side4_reg.sector)
            SEC_0: begin
                red_next = side4_reg.val; green_next = lvl_t; blue_next = lvl_p;
            end
            SEC_1: begin
                red_next = lvl_q; green_next = side4_reg.val; blue_next = lvl_p;
            end
            SEC_2: begin
                red_next = lvl_p; green_next = side4_reg.val; blue_next = lvl_t;
            end
            SEC_3: begin
                red_next = lvl_p; green_next = lvl_q; blue_next = side4_reg.val;
            end
            SEC_4: begin
                red_next = lvl_t; green_next = lvl_p; blue_next = side4_reg.val;
            end
            default: begin
                red_next = side4_reg.val; green_next = lvl_p; blue_next = lvl_q;
            end
        endcase
        if (side4_reg.grey) begin
            red_next   = side4_reg.val;
            green_next = side4_reg.val;
            blue_next  = side4_reg.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_tvalid = valid_reg[NSTAGE-1];
    assign m_tdata  = {blue_reg, green_reg, red_reg};

    // A ready receiver always lets the pipe advance, so input is never blocked then.
    a_ready_through: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while the output was ready");

    // Input is refused when every stage holds a pixel and the output is stuck.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready && (&valid_reg)) |-> !s_tready)
        else $error("input taken while the pipe was full and stalled");

    // A grey pixel leaves with all three channels equal.
    a_grey_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[3] && ld[4] && side4_reg.grey) |=>
            (red_reg == green_reg && green_reg == blue_reg))
        else $error("grey pixel with unequal channels");

    // No channel ever exceeds the brightness of its pixel.
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[3] && ld[4]) |=>
            (red_reg <= $past(side4_reg.val) && green_reg <= $past(side4_reg.val)
             && blue_reg <= $past(side4_reg.val)))
        else $error("channel above brightness");

endmodule

`default_nettype wire
